// ----- hdl/bsm_pkg.sv -----
// ----------------------------------------------------------------------------
// bsm_pkg
// shared constants and types of the 3x3 clipped box smoothing unit
// ----------------------------------------------------------------------------
package bsm_pkg;

   localparam int BSM_MAX_SIDE      = 1024;
   localparam int BSM_CHANNEL_BITS  = 16;
   localparam int BSM_PIX_BITS      = 16;   // port width of one color channel
   localparam int BSM_POS_BITS      = 10;   // port width of row and column
   localparam int BSM_SIDE_BITS     = 11;   // width of the side register
   localparam logic [BSM_SIDE_BITS-1:0] BSM_SIDE_RESET = 11'd512;
   localparam int BSM_QUEUE_DEPTH   = 4;
   localparam int BSM_QCNT_BITS     = $clog2(BSM_QUEUE_DEPTH + 1);

   // position and border flags of one window, front to back
   typedef struct packed {
      logic [BSM_POS_BITS-1:0] row;
      logic [BSM_POS_BITS-1:0] col;
      logic                    r_ge1;
      logic                    r_ge2;
      logic                    c_ge1;
      logic                    c_ge2;
      logic                    r_last;
      logic                    c_last;
      logic                    done;
   } tag_type;

endpackage

// ----- hdl/bsm_channels.sv -----
// ----------------------------------------------------------------------------
// bsm channels
// valid/ready channels for input pixels and smoothed results
// ----------------------------------------------------------------------------
interface bsm_req_if import bsm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [BSM_PIX_BITS-1:0] in_red;
   logic [BSM_PIX_BITS-1:0] in_green;
   logic [BSM_PIX_BITS-1:0] in_blue;

   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bsm_rsp_if import bsm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [BSM_PIX_BITS-1:0] out_red;
   logic [BSM_PIX_BITS-1:0] out_green;
   logic [BSM_PIX_BITS-1:0] out_blue;
   logic [BSM_POS_BITS-1:0] out_row;
   logic [BSM_POS_BITS-1:0] out_col;
   logic                    run_last;
   logic                    frame_done;

   modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                   run_last, frame_done, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
                   run_last, frame_done, output ready);
endinterface

// ----- hdl/bsm_front.sv -----
// ----------------------------------------------------------------------------
// bsm_front
// raster counters, line stores and 3x3 window; pushes one window per pixel
// ----------------------------------------------------------------------------
module bsm_front import bsm_pkg::*; #(
   parameter int MAX_SIDE     = BSM_MAX_SIDE,
   parameter int CHANNEL_BITS = BSM_CHANNEL_BITS,
   localparam int PXW         = 3 * CHANNEL_BITS,
   localparam int WIN_BITS    = 9 * PXW
) (
   input  logic                     clock,
   input  logic                     reset,
   bsm_req_if.sink                  req_chan,
   input  logic                     csr_wr_en,
   input  logic [BSM_SIDE_BITS-1:0] csr_wr_data,
   input  logic [BSM_QCNT_BITS-1:0] q_level,
   output logic                     push,
   output tag_type                  push_tag,
   output logic [WIN_BITS-1:0]      push_win
);

   localparam int CW = $clog2(MAX_SIDE);
   localparam int NW = $clog2(MAX_SIDE + 1);
   localparam int XW = (NW > BSM_SIDE_BITS) ? NW : BSM_SIDE_BITS;
   localparam int LW = BSM_QCNT_BITS + 1;

   logic [BSM_SIDE_BITS-1:0] side_ff;
   logic [XW-1:0]            side_x;
   logic [XW-1:0]            eff_x;
   logic [NW-1:0]            side_n;
   logic [CW-1:0]            row_ff, col_ff;
   logic [NW-1:0]            row_n, col_n;
   logic                     r_end, c_end;
   logic                     accept;
   logic [PXW-1:0]           px;
   logic [PXW-1:0]           up1_ff, up2_ff;
   logic [PXW-1:0]           newer_mem [MAX_SIDE];
   logic [PXW-1:0]           older_mem [MAX_SIDE];
   logic                     s1_valid_ff;
   logic [PXW-1:0]           s1_px_ff;
   logic [CW-1:0]            s1_col_ff;
   tag_type                  s1_tag_ff;
   tag_type                  tag_in;
   logic [PXW-1:0]           win_ff [3][3];
   logic [PXW-1:0]           win_in [3][3];

   // side register; zero acts as one, large values clamp to the store depth
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= BSM_SIDE_RESET;
      end else if (csr_wr_en) begin
         side_ff <= csr_wr_data;
      end
   end

   always_comb begin
      side_x = XW'(side_ff);
      if (side_x == '0) begin
         eff_x = XW'(1);
      end else if (side_x > XW'(MAX_SIDE)) begin
         eff_x = XW'(MAX_SIDE);
      end else begin
         eff_x = side_x;
      end
      side_n = NW'(eff_x);
   end

   assign row_n  = NW'(row_ff);
   assign col_n  = NW'(col_ff);
   assign c_end  = !((col_n + NW'(1)) < side_n);
   assign r_end  = !((row_n + NW'(1)) < side_n);

   assign req_chan.ready = (LW'(q_level) + LW'(s1_valid_ff)) < LW'(BSM_QUEUE_DEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   assign px = {req_chan.in_blue[CHANNEL_BITS-1:0], req_chan.in_green[CHANNEL_BITS-1:0],
                req_chan.in_red[CHANNEL_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (!c_end) begin
            col_ff <= col_ff + CW'(1);
         end else begin
            col_ff <= '0;
            row_ff <= r_end ? '0 : row_ff + CW'(1);
         end
      end
   end

   always_comb begin
      tag_in.row    = BSM_POS_BITS'(row_ff);
      tag_in.col    = BSM_POS_BITS'(col_ff);
      tag_in.r_ge1  = (row_ff != '0);
      tag_in.r_ge2  = (row_ff >= CW'(2));
      tag_in.c_ge1  = (col_ff != '0);
      tag_in.c_ge2  = (col_ff >= CW'(2));
      tag_in.r_last = r_end;
      tag_in.c_last = c_end;
      tag_in.done   = r_end && c_end;
   end

   // newer line: read old row above, then overwrite with this pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         up1_ff            <= newer_mem[col_ff];
         newer_mem[col_ff] <= px;
      end
   end

   // older line: takes the row above in the cycle after the newer line is read
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         older_mem[s1_col_ff] <= up1_ff;
      end
      if (accept) begin
         up2_ff <= older_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff  <= px;
         s1_col_ff <= col_ff;
         s1_tag_ff <= tag_in;
      end
   end

   // window shifts left, new column on the right
   always_comb begin
      for (int y = 0; y < 3; y++) begin
         win_in[y][0] = win_ff[y][1];
         win_in[y][1] = win_ff[y][2];
      end
      win_in[0][2] = up2_ff;
      win_in[1][2] = up1_ff;
      win_in[2][2] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      for (int y = 0; y < 3; y++) begin
         for (int x = 0; x < 3; x++) begin
            push_win[(y * 3 + x) * PXW +: PXW] = win_in[y][x];
         end
      end
   end

   assign push     = s1_valid_ff;
   assign push_tag = s1_tag_ff;

endmodule

// ----- hdl/bsm_queue.sv -----
// ----------------------------------------------------------------------------
// bsm_queue
// short fifo of windows between front and back
// ----------------------------------------------------------------------------
module bsm_queue import bsm_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic                     head_valid,
   output logic [WIDTH-1:0]         head_data,
   output logic [BSM_QCNT_BITS-1:0] level
);

   localparam int PW = $clog2(BSM_QUEUE_DEPTH);

   logic [WIDTH-1:0]         slot_ff [BSM_QUEUE_DEPTH];
   logic [PW-1:0]            wr_ptr_ff, rd_ptr_ff;
   logic [BSM_QCNT_BITS-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + BSM_QCNT_BITS'(push) - BSM_QCNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign level      = count_ff;

endmodule

// ----- hdl/bsm_back.sv -----
// ----------------------------------------------------------------------------
// bsm_back
// expands each window into up to four results; sum, reciprocal multiply
// ----------------------------------------------------------------------------
module bsm_back import bsm_pkg::*; #(
   parameter int CHANNEL_BITS = BSM_CHANNEL_BITS,
   localparam int PXW         = 3 * CHANNEL_BITS,
   localparam int WIN_BITS    = 9 * PXW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  tag_type             head_tag,
   input  logic [WIN_BITS-1:0] head_win,
   output logic                pop,
   bsm_rsp_if.source           rsp_chan
);

   localparam int CB   = CHANNEL_BITS;
   localparam int COLW = CB + 2;
   localparam int SUMW = CB + 4;
   localparam int SH   = CB + 12;
   localparam int MW   = SH + 1;
   localparam int PRW  = SUMW + MW;
   localparam longint ONE = longint'(1) << SH;
   localparam logic [MW-1:0] RECIP_1 = MW'(ONE);
   localparam logic [MW-1:0] RECIP_2 = MW'((ONE + 1) / 2);
   localparam logic [MW-1:0] RECIP_3 = MW'((ONE + 2) / 3);
   localparam logic [MW-1:0] RECIP_4 = MW'((ONE + 3) / 4);
   localparam logic [MW-1:0] RECIP_6 = MW'((ONE + 5) / 6);
   localparam logic [MW-1:0] RECIP_9 = MW'((ONE + 8) / 9);

   logic [3:0]              want, emitted_ff, rem, sel;
   logic                    has, is_last, en, issue;
   logic                    di, dj;
   logic [2:0]              rmask, cmask;
   logic [1:0]              nr, nc;
   logic [COLW-1:0]         colsum_in [3][3];

   logic                    a_valid_ff;
   logic [COLW-1:0]         a_colsum_ff [3][3];
   logic [2:0]              a_cmask_ff;
   logic [1:0]              a_nr_ff, a_nc_ff;
   logic [BSM_POS_BITS-1:0] a_row_ff, a_col_ff;
   logic                    a_last_ff, a_done_ff;

   logic [SUMW-1:0]         total_in [3];
   logic [MW-1:0]           recip_in;
   logic                    b_valid_ff;
   logic [SUMW-1:0]         b_total_ff [3];
   logic [MW-1:0]           b_recip_ff;
   logic [BSM_POS_BITS-1:0] b_row_ff, b_col_ff;
   logic                    b_last_ff, b_done_ff;

   logic                    c_valid_ff;
   logic [PRW-1:0]          c_prod_ff [3];
   logic [BSM_POS_BITS-1:0] c_row_ff, c_col_ff;
   logic                    c_last_ff, c_done_ff;

   logic                    d_valid_ff;
   logic [BSM_PIX_BITS-1:0] d_pix_ff [3];
   logic [BSM_POS_BITS-1:0] d_row_ff, d_col_ff;
   logic                    d_last_ff, d_done_ff;

   // result slots in raster order: up-left, up, left, here
   assign want = {head_tag.r_last && head_tag.c_last, head_tag.r_last && head_tag.c_ge1,
                  head_tag.r_ge1 && head_tag.c_last, head_tag.r_ge1 && head_tag.c_ge1};
   assign rem     = want & ~emitted_ff;
   assign sel     = rem & (~rem + 4'd1);
   assign has     = (rem != 4'd0);
   assign is_last = ((rem & ~sel) == 4'd0);
   assign en      = !d_valid_ff || rsp_chan.ready;
   assign issue   = en && head_valid && has;
   assign pop     = en && head_valid && (!has || is_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         emitted_ff <= '0;
      end else if (en && head_valid) begin
         emitted_ff <= pop ? 4'd0 : (emitted_ff | sel);
      end
   end

   assign di = sel[0] || sel[1];
   assign dj = sel[0] || sel[2];
   assign rmask = di ? {2'b11, head_tag.r_ge2} : {1'b1, head_tag.r_ge1, 1'b0};
   assign cmask = dj ? {2'b11, head_tag.c_ge2} : {1'b1, head_tag.c_ge1, 1'b0};
   assign nr = {1'b0, rmask[0]} + {1'b0, rmask[1]} + {1'b0, rmask[2]};
   assign nc = {1'b0, cmask[0]} + {1'b0, cmask[1]} + {1'b0, cmask[2]};

   // column sums over the clipped rows
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int x = 0; x < 3; x++) begin
            colsum_in[ch][x] = '0;
            for (int y = 0; y < 3; y++) begin
               if (rmask[y]) begin
                  colsum_in[ch][x] = colsum_in[ch][x]
                     + COLW'(head_win[((y * 3 + x) * 3 + ch) * CB +: CB]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= issue;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_colsum_ff <= colsum_in;
         a_cmask_ff  <= cmask;
         a_nr_ff     <= nr;
         a_nc_ff     <= nc;
         a_row_ff    <= head_tag.row - BSM_POS_BITS'(di);
         a_col_ff    <= head_tag.col - BSM_POS_BITS'(dj);
         a_last_ff   <= is_last;
         a_done_ff   <= head_tag.done;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         total_in[ch] = '0;
         for (int x = 0; x < 3; x++) begin
            if (a_cmask_ff[x]) begin
               total_in[ch] = total_in[ch] + SUMW'(a_colsum_ff[ch][x]);
            end
         end
      end
   end

   // reciprocal of the clipped pixel count
   always_comb begin
      unique case ({a_nr_ff, a_nc_ff}) inside
         4'b0101:          recip_in = RECIP_1;
         4'b0110, 4'b1001: recip_in = RECIP_2;
         4'b0111, 4'b1101: recip_in = RECIP_3;
         4'b1010:          recip_in = RECIP_4;
         4'b1011, 4'b1110: recip_in = RECIP_6;
         4'b1111:          recip_in = RECIP_9;
         default:          recip_in = RECIP_1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_total_ff <= total_in;
         b_recip_ff <= recip_in;
         b_row_ff   <= a_row_ff;
         b_col_ff   <= a_col_ff;
         b_last_ff  <= a_last_ff;
         b_done_ff  <= a_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < 3; ch++) begin
            c_prod_ff[ch] <= PRW'(b_total_ff[ch]) * PRW'(b_recip_ff);
         end
         c_row_ff  <= b_row_ff;
         c_col_ff  <= b_col_ff;
         c_last_ff <= b_last_ff;
         c_done_ff <= b_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < 3; ch++) begin
            d_pix_ff[ch] <= BSM_PIX_BITS'(c_prod_ff[ch][SH +: CB]);
         end
         d_row_ff  <= c_row_ff;
         d_col_ff  <= c_col_ff;
         d_last_ff <= c_last_ff;
         d_done_ff <= c_done_ff;
      end
   end

   assign rsp_chan.valid      = d_valid_ff;
   assign rsp_chan.out_red    = d_pix_ff[0];
   assign rsp_chan.out_green  = d_pix_ff[1];
   assign rsp_chan.out_blue   = d_pix_ff[2];
   assign rsp_chan.out_row    = d_row_ff;
   assign rsp_chan.out_col    = d_col_ff;
   assign rsp_chan.run_last   = d_last_ff;
   assign rsp_chan.frame_done = d_done_ff;

endmodule

// ----- hdl/box_smooth_3x3_edge_clipped_unit.sv -----
// ----------------------------------------------------------------------------
// box_smooth_3x3_edge_clipped_unit
// 3x3 mean filter over a raster-order rgb image, clipped at the border
//
//   channel   | direction | transaction
//   req_chan  | in        | one rgb pixel in raster order
//   rsp_chan  | out       | one smoothed pixel with row, column and flags
//   csr_*     | in        | write of the image side, restarts the frame
//
// one pixel per clock sustained while results are taken; the front (line
// stores, window) takes a pixel every cycle while the queue has room, the back
// emits one result a cycle while the output is ready; a pixel releasing several
// results holds the back until all are issued, so the last row stalls the front
// the front pushes from its s1 registers; the back has 4 register stages, a to d
// reset is synchronous; line stores are not cleared, border clipping never
// uses an unwritten entry
// a stalled result holds the back; the queue then fills and the front stalls
// ----------------------------------------------------------------------------
module box_smooth_3x3_edge_clipped_unit import bsm_pkg::*; #(
   parameter int MAX_SIDE     = BSM_MAX_SIDE,
   parameter int CHANNEL_BITS = BSM_CHANNEL_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   bsm_req_if.sink                  req_chan,
   bsm_rsp_if.source                rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [BSM_SIDE_BITS-1:0] csr_wr_data
);

   localparam int WIN_BITS = 9 * 3 * CHANNEL_BITS;
   localparam int QW       = $bits(tag_type) + WIN_BITS;

   // front to queue
   logic                     push;
   tag_type                  push_tag;
   logic [WIN_BITS-1:0]      push_win;
   // queue to back
   logic                     head_valid;
   logic [QW-1:0]            head_data;
   tag_type                  head_tag;
   logic [WIN_BITS-1:0]      head_win;
   logic                     pop;
   logic [BSM_QCNT_BITS-1:0] q_level;

   bsm_front #(
      .MAX_SIDE     (MAX_SIDE),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_level     (q_level),
      .push        (push),
      .push_tag    (push_tag),
      .push_win    (push_win)
   );

   // window snapshots wait here while the back expands earlier ones
   bsm_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_tag, push_win}),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .level      (q_level)
   );

   assign head_tag = head_data[QW-1 -: $bits(tag_type)];
   assign head_win = head_data[WIN_BITS-1:0];

   bsm_back #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_tag   (head_tag),
      .head_win   (head_win),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTHESIS
   // front credit check must keep the queue from overflowing
   assert property (@(posedge clock) disable iff (reset)
      push && (q_level == BSM_QCNT_BITS'(BSM_QUEUE_DEPTH)) |-> pop)
      else $error("queue overflow");

   // back never pops an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_level != '0))
      else $error("queue underflow");

   // after an accepted pixel the queue level must stay within its depth
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> (q_level <= BSM_QCNT_BITS'(BSM_QUEUE_DEPTH)))
      else $error("queue level out of range");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
`endif

endmodule
